@@ hdl/ctmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ctmcs_pkg
// Shared types and constants for the controller-to-mouse click synthesizer.
// ----------------------------------------------------------------------------
package ctmcs_pkg;

  localparam int MAX_STEPS = 8;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int ACC_W     = 20;
  localparam int THR_W     = 15;
  localparam int DIV_W     = 17;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CTL_W     = 4;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1638);

  localparam logic       OP_BUTTON  = 1'b0;
  localparam logic       OP_TOUCH   = 1'b1;
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  typedef enum logic [2:0] {
    CLICK_LEFT   = 3'd0,
    CLICK_RIGHT  = 3'd1,
    CLICK_MIDDLE = 3'd2,
    CLICK_UP     = 3'd3,
    CLICK_DOWN   = 3'd4,
    CLICK_SLEFT  = 3'd5,
    CLICK_SRIGHT = 3'd6
  } click_code_t;

  typedef struct packed {
    logic              operation;
    logic [CTL_W-1:0]  controller_id;
    logic [1:0]        button;
    logic              pressed;
    logic              changed;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } in_item_t;

  typedef struct packed {
    click_code_t      click_code;
    logic             click_pressed;
    logic [CTL_W-1:0] owner_controller;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_START_Y,
    ST_WAIT_Y,
    ST_WAIT_X,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic decide;
    logic div_start;
    logic div_sel_x;
    logic load_y;
    logic load_x;
    logic emit_take;
  } ctl_cmd_t;

  typedef struct packed {
    logic touch_go;
    logic div_done;
    logic emit_has;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/controller_to_mouse_click_synth_core.sv @@
// ----------------------------------------------------------------------------
// controller_to_mouse_click_synth_core
// Button events: after decide, the click word is loaded into the output register.
// Touch events: two divisions run in turn on one shared divider, then one word
// per cycle is emitted while out_ready is high (up to 32 words).
// One item in flight at a time; the output register frees the input side.
// Sync active-high rst resets FSM, owner, masks, counters; threshold to 1638.
// ----------------------------------------------------------------------------
module controller_to_mouse_click_synth_core import ctmcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  ctmcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ctmcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/ctmcs_div.sv @@
// ----------------------------------------------------------------------------
// ctmcs_div
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctmcs_div import ctmcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [THR_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quo,
  output logic [THR_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [THR_W:0]       part;
  logic                 ge;
  logic [THR_W:0]       diff;

  assign part = {rem, quo[DIV_W-1]};
  assign ge   = part >= {1'b0, divisor};
  assign diff = part - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? diff[THR_W-1:0] : part[THR_W-1:0];
    end
  end

endmodule

@@ hdl/ctmcs_dp.sv @@
// ----------------------------------------------------------------------------
// ctmcs_dp
// Datapath: item capture, threshold, owner and button state, touch accumulators,
// step counters, the divider, release sequencing and the output register.
// ----------------------------------------------------------------------------
module ctmcs_dp import ctmcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data,
  input  ctl_cmd_t         cmd,
  output dp_status_t       status,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  in_item_t                item;
  logic [THR_W-1:0]        threshold;
  logic [CTL_W-1:0]        primary_owner;
  logic [CTL_W-1:0]        emit_owner;
  logic [2:0]              held_mask;
  logic [2:0]              rel_mask;
  logic                    btn_pend;
  logic [15:0]             prev_touch_x;
  logic [15:0]             prev_touch_y;
  logic signed [ACC_W-1:0] accum_x;
  logic signed [ACC_W-1:0] accum_y;
  logic [STEP_W-1:0]       cnt_x;
  logic [STEP_W-1:0]       cnt_y;
  logic                    y_neg;
  logic                    x_neg;
  logic                    phase;

  logic             ctl_ok;
  logic             owner_match;
  logic             btn_ok;
  logic             new_pri;
  logic             btn_go;
  logic             touch_hit;
  logic             touch_go;
  logic [THR_W-1:0] thr_eff;
  logic [ACC_W-1:0] mag_x;
  logic [ACC_W-1:0] mag_y;
  logic [DIV_W-1:0] dividend;
  logic             div_done;
  logic [DIV_W-1:0] quo;
  logic [THR_W-1:0] rem;
  logic [STEP_W-1:0] steps;
  logic [ACC_W-1:0] rem_pos;
  logic [2:0]       rel_pick;
  logic             out_free;
  logic             emit_has;
  out_item_t        emit_item;

  assign ctl_ok      = item.controller_id != '0;
  assign owner_match = primary_owner == item.controller_id;
  assign btn_ok      = item.button != 2'd3;
  assign new_pri     = ctl_ok && item.operation == OP_BUTTON && item.button == BTN_LEFT
                       && item.pressed && !owner_match;
  assign btn_go      = ctl_ok && item.operation == OP_BUTTON && btn_ok && !new_pri
                       && owner_match && item.changed;
  assign touch_hit   = ctl_ok && item.operation == OP_TOUCH && owner_match;
  assign touch_go    = touch_hit && !(item.touch_x == '0 && item.touch_y == '0)
                       && !(prev_touch_x == '0 && prev_touch_y == '0);

  assign thr_eff  = (threshold == '0) ? THR_W'(1) : threshold;
  assign mag_x    = accum_x[ACC_W-1] ? -accum_x : accum_x;
  assign mag_y    = accum_y[ACC_W-1] ? -accum_y : accum_y;
  assign dividend = cmd.div_sel_x ? mag_x[DIV_W-1:0] : mag_y[DIV_W-1:0];
  assign steps    = (quo > DIV_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : quo[STEP_W-1:0];
  assign rem_pos  = ACC_W'(rem);

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  ctmcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (thr_eff),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // release order: left, middle, right
  always_comb begin
    if (rel_mask[0]) begin
      rel_pick = 3'b001;
    end else if (rel_mask[2]) begin
      rel_pick = 3'b100;
    end else begin
      rel_pick = 3'b010;
    end
  end

  always_comb begin
    emit_has                   = 1'b1;
    emit_item.owner_controller = emit_owner;
    emit_item.click_code       = CLICK_LEFT;
    emit_item.click_pressed    = 1'b0;
    emit_item.last_of_run      = 1'b0;
    if (rel_mask != '0) begin
      emit_item.click_code  = rel_pick[0] ? CLICK_LEFT : (rel_pick[2] ? CLICK_MIDDLE : CLICK_RIGHT);
      emit_item.last_of_run = (rel_mask & ~rel_pick) == '0;
    end else if (btn_pend) begin
      emit_item.click_code    = click_code_t'({1'b0, item.button});
      emit_item.click_pressed = item.pressed;
      emit_item.last_of_run   = 1'b1;
    end else if (cnt_y != '0) begin
      emit_item.click_code    = y_neg ? CLICK_DOWN : CLICK_UP;
      emit_item.click_pressed = !phase;
      emit_item.last_of_run   = phase && cnt_y == STEP_W'(1) && cnt_x == '0;
    end else if (cnt_x != '0) begin
      emit_item.click_code    = x_neg ? CLICK_SLEFT : CLICK_SRIGHT;
      emit_item.click_pressed = !phase;
      emit_item.last_of_run   = phase && cnt_x == STEP_W'(1);
    end else begin
      emit_has = 1'b0;
    end
  end

  assign status.touch_go = touch_go;
  assign status.div_done = div_done;
  assign status.emit_has = emit_has;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.decide) begin
      emit_owner <= primary_owner;
    end
    if (cmd.load_y) begin
      y_neg <= accum_y[ACC_W-1];
    end
    if (cmd.load_x) begin
      x_neg <= accum_x[ACC_W-1];
    end
    if (cmd.emit_take) begin
      out_data <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THR_RESET;
      primary_owner <= '0;
      held_mask     <= '0;
      rel_mask      <= '0;
      btn_pend      <= 1'b0;
      prev_touch_x  <= '0;
      prev_touch_y  <= '0;
      accum_x       <= '0;
      accum_y       <= '0;
      cnt_x         <= '0;
      cnt_y         <= '0;
      phase         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (cmd.decide) begin
        if (new_pri) begin
          accum_x       <= '0;
          accum_y       <= '0;
          rel_mask      <= held_mask;
          held_mask     <= '0;
          primary_owner <= item.controller_id;
        end
        if (btn_go) begin
          btn_pend <= 1'b1;
          held_mask[item.button] <= item.pressed;
        end
        if (touch_hit) begin
          prev_touch_x <= item.touch_x;
          prev_touch_y <= item.touch_y;
        end
        if (touch_go) begin
          accum_x <= accum_x + ACC_W'(item.delta_x);
          accum_y <= accum_y + ACC_W'(item.delta_y);
        end
      end
      if (cmd.load_y) begin
        accum_y <= accum_y[ACC_W-1] ? -rem_pos : rem_pos;
        cnt_y   <= steps;
      end
      if (cmd.load_x) begin
        accum_x <= accum_x[ACC_W-1] ? -rem_pos : rem_pos;
        cnt_x   <= steps;
      end
      if (cmd.emit_take) begin
        out_valid <= 1'b1;
        if (rel_mask != '0) begin
          rel_mask <= rel_mask & ~rel_pick;
        end else if (btn_pend) begin
          btn_pend <= 1'b0;
        end else begin
          phase <= !phase;
          if (phase) begin
            if (cnt_y != '0) begin
              cnt_y <= cnt_y - 1'b1;
            end else begin
              cnt_x <= cnt_x - 1'b1;
            end
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/ctmcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctmcs_ctrl
// Controller: sequences capture, decode, the two divisions and emission.
// ----------------------------------------------------------------------------
module ctmcs_ctrl import ctmcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = status.touch_go ? ST_START_Y : ST_EMIT;
      end
      ST_START_Y: begin
        state_next = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (status.div_done) begin
          state_next = ST_WAIT_X;
        end
      end
      ST_WAIT_X: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.emit_has) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_START_Y: begin
        cmd.div_start = 1'b1;
      end
      ST_WAIT_Y: begin
        cmd.load_y    = status.div_done;
        cmd.div_start = status.div_done;
        cmd.div_sel_x = 1'b1;
      end
      ST_WAIT_X: begin
        cmd.load_x = status.div_done;
      end
      ST_EMIT: begin
        cmd.emit_take = status.emit_has && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
